// ===== hw/rtl/tnr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnr_pkg
// Shared constants and types for the telnet receive negotiator.
// ----------------------------------------------------------------------------
package tnr_pkg;

  localparam int unsigned OPTION_COUNT = 32;
  localparam int unsigned OPT_IDX_W    = (OPTION_COUNT > 1) ? $clog2(OPTION_COUNT) : 1;
  localparam int unsigned MASK_W       = 32;
  localparam int unsigned MASK_IDX_W   = $clog2(MASK_W);
  localparam int unsigned PADDR_W      = 2;

  localparam logic [MASK_W-1:0]  ACCEPT_MASK_RST = MASK_W'(9);
  localparam logic [PADDR_W-1:0] ADDR_ACCEPT_MASK = PADDR_W'(0);

  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_SE   = 8'd240;

  localparam logic DEST_APP  = 1'b0;
  localparam logic DEST_PEER = 1'b1;

  // one queued job: a data byte or a three-beat reply
  typedef struct packed {
    logic       is_reply;
    logic [7:0] verb;
    logic [7:0] value;
  } job_t;

  // queue status seen by the front end
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== hw/rtl/tnr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnr_front
// Byte parser and option flag sets; turns each received byte into at most
// one queued job.
// ----------------------------------------------------------------------------
module tnr_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rx_valid_i,
  output logic                     rx_ready_o,
  input  logic [7:0]               rx_byte_i,
  input  logic [31:0]              accept_mask_i,
  input  tnr_pkg::q_stat_t         q_stat_i,
  output logic                     push_o,
  output tnr_pkg::job_t            job_o
);
  import tnr_pkg::*;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_IAC  = 3'd1;
  localparam logic [2:0] PH_DONT = 3'd2;
  localparam logic [2:0] PH_DO   = 3'd3;
  localparam logic [2:0] PH_WONT = 3'd4;
  localparam logic [2:0] PH_WILL = 3'd5;
  localparam logic [2:0] PH_SKIP = 3'd6;

  logic [2:0]              phase_q, phase_d;
  logic [OPTION_COUNT-1:0] wanted_q, wanted_d;
  logic [OPTION_COUNT-1:0] tried_q, tried_d;
  logic [OPTION_COUNT-1:0] offered_q, offered_d;
  logic [OPTION_COUNT-1:0] agreed_q, agreed_d;

  logic                 acc;
  logic                 in_range;
  logic [OPT_IDX_W-1:0] idx;
  logic                 mask_ok;
  logic                 neg;
  logic [7:0]           verb;
  logic                 positive;
  logic                 tried, wanted, offered, agreed, take;
  logic                 send;

  assign rx_ready_o = !q_stat_i.full;
  assign acc        = rx_valid_i && rx_ready_o;

  assign in_range = {1'b0, rx_byte_i} < 9'(OPTION_COUNT);
  assign idx      = rx_byte_i[OPT_IDX_W-1:0];
  assign mask_ok  = (rx_byte_i < 8'(MASK_W)) && accept_mask_i[rx_byte_i[MASK_IDX_W-1:0]];

  always_comb begin
    neg  = 1'b1;
    verb = B_WONT;
    case (phase_q)
      PH_DONT: verb = B_WONT;
      PH_DO:   verb = mask_ok ? B_WILL : B_WONT;
      PH_WONT: verb = B_DONT;
      PH_WILL: verb = mask_ok ? B_DO : B_DONT;
      default: neg  = 1'b0;
    endcase
  end

  assign positive = (verb == B_WILL) || (verb == B_DO);
  assign tried    = in_range && tried_q[idx];
  assign wanted   = in_range && wanted_q[idx];
  assign offered  = in_range && positive;
  assign take     = tried && (wanted == offered);
  assign agreed   = in_range && (take ? offered : agreed_q[idx]);
  assign send     = (agreed != offered) || !tried;

  always_comb begin
    phase_d   = phase_q;
    wanted_d  = wanted_q;
    tried_d   = tried_q;
    offered_d = offered_q;
    agreed_d  = agreed_q;
    push_o    = 1'b0;
    job_o     = '{is_reply: 1'b0, verb: verb, value: rx_byte_i};
    if (acc) begin
      phase_d = PH_IDLE;
      case (phase_q)
        PH_IDLE: begin
          if (rx_byte_i == B_IAC) begin
            phase_d = PH_IAC;
          end else begin
            push_o = 1'b1;
          end
        end
        PH_IAC: begin
          if (rx_byte_i == B_IAC) begin
            push_o = 1'b1;
          end else if (rx_byte_i == B_DONT) begin
            phase_d = PH_DONT;
          end else if (rx_byte_i == B_DO) begin
            phase_d = PH_DO;
          end else if (rx_byte_i == B_WONT) begin
            phase_d = PH_WONT;
          end else if (rx_byte_i == B_WILL) begin
            phase_d = PH_WILL;
          end else if (rx_byte_i == B_SB || rx_byte_i == B_SE) begin
            phase_d = PH_SKIP;
          end
        end
        default: begin
          if (neg) begin
            if (in_range) begin
              offered_d[idx] = positive;
              if (take) begin
                agreed_d[idx] = offered;
              end
              if (send) begin
                tried_d[idx]  = 1'b1;
                wanted_d[idx] = positive;
              end
            end
            if (send) begin
              push_o         = 1'b1;
              job_o.is_reply = 1'b1;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      wanted_q  <= '0;
      tried_q   <= '0;
      offered_q <= '0;
      agreed_q  <= '0;
    end else begin
      phase_q   <= phase_d;
      wanted_q  <= wanted_d;
      tried_q   <= tried_d;
      offered_q <= offered_d;
      agreed_q  <= agreed_d;
    end
  end

endmodule

// ===== hw/rtl/tnr_job_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnr_job_queue
// Two-entry job queue between the parser and the output sequencer.
// ----------------------------------------------------------------------------
module tnr_job_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tnr_pkg::job_t     job_i,
  input  logic              pop_i,
  output tnr_pkg::job_t     head_o,
  output tnr_pkg::q_stat_t  stat_o,
  output logic [1:0]        count_o
);
  import tnr_pkg::*;

  job_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign stat_o.full  = (count_q == 2'd2);
  assign stat_o.empty = (count_q == 2'd0);
  assign count_o      = count_q;
  assign head_o       = mem_q[rd_ptr_q];

  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== hw/rtl/tnr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnr_back
// Output sequencer; sends one beat per data job and three per reply job.
// ----------------------------------------------------------------------------
module tnr_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tnr_pkg::job_t     head_i,
  input  tnr_pkg::q_stat_t  q_stat_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              dest_o,
  output logic [7:0]        out_byte_o,
  output logic              last_of_run_o
);
  import tnr_pkg::*;

  logic [1:0] beat_q, beat_d;
  logic       fire;

  assign out_valid_o   = !q_stat_i.empty;
  assign fire          = out_valid_o && out_ready_i;
  assign dest_o        = head_i.is_reply ? DEST_PEER : DEST_APP;
  assign last_of_run_o = !head_i.is_reply || (beat_q == 2'd2);
  assign pop_o         = fire && last_of_run_o;

  always_comb begin
    case (beat_q)
      2'd0:    out_byte_o = head_i.is_reply ? B_IAC : head_i.value;
      2'd1:    out_byte_o = head_i.verb;
      default: out_byte_o = head_i.value;
    endcase
  end

  always_comb begin
    beat_d = beat_q;
    if (fire) begin
      beat_d = last_of_run_o ? 2'd0 : beat_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= 2'd0;
    end else begin
      beat_q <= beat_d;
    end
  end

endmodule

// ===== hw/rtl/telnet_receive_negotiator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telnet_receive_negotiator
// Telnet receive-side parser and option negotiator with an APB register port.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle while the queue has room. A plain
// byte or an escaped 255 gives one beat to the application; a negotiation
// that needs an answer gives three reply beats, sent one per cycle while
// out_ready_i is high. The parser and flag update push jobs into a two-entry
// queue; the output sequencer drains it, so rx_ready_o drops only while the
// queue is full, when replies outpace their three beats or the output stalls.
module telnet_receive_negotiator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rx_valid_i,
  output logic                         rx_ready_o,
  input  logic [7:0]                   rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         dest_o,
  output logic [7:0]                   out_byte_o,
  output logic                         last_of_run_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tnr_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import tnr_pkg::*;

  logic [MASK_W-1:0] accept_mask_q;
  q_stat_t           q_stat;
  job_t              job, head;
  logic              push, pop;
  logic [1:0]        q_count;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_ACCEPT_MASK) ? accept_mask_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accept_mask_q <= ACCEPT_MASK_RST;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_ACCEPT_MASK) begin
      accept_mask_q <= pwdata;
    end
  end

  tnr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_valid_i    (rx_valid_i),
    .rx_ready_o    (rx_ready_o),
    .rx_byte_i     (rx_byte_i),
    .accept_mask_i (accept_mask_q),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .job_o         (job)
  );

  tnr_job_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (q_stat),
    .count_o (q_count)
  );

  tnr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .q_stat_i      (q_stat),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .dest_o        (dest_o),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count != 2'd3)
    else $error("job queue count out of range");

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_ready_o |-> q_count == 2'd2)
    else $error("input stalled with room in queue");

  a_data_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dest_o == DEST_APP |-> last_of_run_o)
    else $error("data beat not marked last");

  a_reply_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && dest_o == DEST_PEER && !last_of_run_o
    |=> out_valid_o && dest_o == DEST_PEER)
    else $error("reply run broken");

endmodule
